FILE: design/tparam_to_zparam_2port_unit_assert.svh
// Assertion macros for the T-to-Z parameter converter.
// Included by modules that check their own pipeline; no other dependencies.
`ifndef TPARAM_TO_ZPARAM_2PORT_UNIT_ASSERT_SVH
`define TPARAM_TO_ZPARAM_2PORT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TZP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define TZP_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define TZP_ASSERT(lbl, clk, rstn, prop, msg)
`define TZP_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

FILE: design/tzp_pkg.sv
// Package for the T-to-Z parameter converter: defaults, status codes, flags, a max helper.
// No dependencies.
package tzp_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_DIV_ZERO = 2'd1,
        STAT_REF_ZERO = 2'd2,
        STAT_SAT      = 2'd3
    } status_t;

    typedef struct packed {
        logic dzero;
        logic rzero;
        logic z1neg;
        logic z2neg;
    } flags_t;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

FILE: design/tparam_to_zparam_2port_unit.sv
// Two-port T to Z parameter converter (power waves), signed fixed point, saturating.
// Pipeline depth: 2*DATA_WIDTH+12 register stages.
// Throughput: one item per cycle while the output is not held; the square root and the eight dividers are
// fully pipelined, one result bit per stage, so their depth sets the latency.
// Reset (aresetn low, synchronous) clears only the stage valid bits.
// Depends on tzp_pkg, tzp_sqrt, tzp_div and the assertion macro header.
`include "tparam_to_zparam_2port_unit_assert.svh"
module tparam_to_zparam_2port_unit #(
    parameter int DATA_WIDTH = tzp_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = tzp_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_t11_re,
    input  logic signed [DATA_WIDTH-1:0] s_t11_im,
    input  logic signed [DATA_WIDTH-1:0] s_t12_re,
    input  logic signed [DATA_WIDTH-1:0] s_t12_im,
    input  logic signed [DATA_WIDTH-1:0] s_t21_re,
    input  logic signed [DATA_WIDTH-1:0] s_t21_im,
    input  logic signed [DATA_WIDTH-1:0] s_t22_re,
    input  logic signed [DATA_WIDTH-1:0] s_t22_im,
    input  logic signed [DATA_WIDTH-1:0] s_ref1_re,
    input  logic signed [DATA_WIDTH-1:0] s_ref1_im,
    input  logic signed [DATA_WIDTH-1:0] s_ref2_re,
    input  logic signed [DATA_WIDTH-1:0] s_ref2_im,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_z11_re,
    output logic signed [DATA_WIDTH-1:0] m_z11_im,
    output logic signed [DATA_WIDTH-1:0] m_z12_re,
    output logic signed [DATA_WIDTH-1:0] m_z12_im,
    output logic signed [DATA_WIDTH-1:0] m_z21_re,
    output logic signed [DATA_WIDTH-1:0] m_z21_im,
    output logic signed [DATA_WIDTH-1:0] m_z22_re,
    output logic signed [DATA_WIDTH-1:0] m_z22_im,
    output logic [1:0]                   m_status
);
    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int SW  = W + 2;          // sums of four fields
    localparam int PW  = 2 * W + 2;      // first-level products
    localparam int NW  = 2 * W + 3;      // Z11/Z22 numerators
    localparam int DTW = 2 * W + 2;      // determinant of T
    localparam int DDW = 2 * W + 4;      // |d|^2
    localparam int GW  = W + 2;          // signed 2*s
    localparam int CW  = W + 1;          // chunk width of wide operands
    localparam int YPW = 2 * GW;         // chunk products
    localparam int TW  = W + 2 + F;      // Z21 numerator
    localparam int MW  = 3 * W + 4;      // lane numerators
    localparam int PZ  = MW + SW;        // lane products
    localparam int RW  = PZ + 1;         // lane sums
    localparam int DNW = DDW + F;        // divider denominator
    localparam int L   = 2 * W + 12;     // pipeline depth

    // Global advance: every stage moves together unless the output is held.
    logic adv;
    logic vld_reg [1:L];
    tzp_pkg::flags_t flg_reg [1:L-1];
    tzp_pkg::flags_t flg_c;

    assign adv     = !vld_reg[L] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[L];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= L; i++) vld_reg[i] <= 1'b0;
        end else if (adv) begin
            vld_reg[1] <= s_valid;
            for (int i = 2; i <= L; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // ---------------- stage 1: sums of T entries, magnitudes, flags --------
    logic signed [SW-1:0] dr_c, di_c;
    logic signed [SW-1:0] e_c [0:7];
    logic [W-1:0]         r1a_c, r2a_c;

    always_comb begin
        dr_c = SW'(s_t21_re) + SW'(s_t22_re) - SW'(s_t11_re) - SW'(s_t12_re);
        di_c = SW'(s_t21_im) + SW'(s_t22_im) - SW'(s_t11_im) - SW'(s_t12_im);
        // Z11 numerator factors: (a+b)x - (ai-bi)y, (a-b)y + (ai+bi)x
        e_c[0] = SW'(s_t11_re) + SW'(s_t12_re) + SW'(s_t21_re) + SW'(s_t22_re);
        e_c[1] = SW'(s_t11_im) + SW'(s_t12_im) - SW'(s_t21_im) - SW'(s_t22_im);
        e_c[2] = SW'(s_t11_re) + SW'(s_t12_re) - SW'(s_t21_re) - SW'(s_t22_re);
        e_c[3] = SW'(s_t11_im) + SW'(s_t12_im) + SW'(s_t21_im) + SW'(s_t22_im);
        // Z22 numerator factors with a = t11-t21, b = t22-t12
        e_c[4] = SW'(s_t11_re) - SW'(s_t21_re) + SW'(s_t22_re) - SW'(s_t12_re);
        e_c[5] = SW'(s_t11_im) - SW'(s_t21_im) - SW'(s_t22_im) + SW'(s_t12_im);
        e_c[6] = SW'(s_t11_re) - SW'(s_t21_re) - SW'(s_t22_re) + SW'(s_t12_re);
        e_c[7] = SW'(s_t11_im) - SW'(s_t21_im) + SW'(s_t22_im) - SW'(s_t12_im);
        r1a_c  = $unsigned(s_ref1_re[W-1] ? -s_ref1_re : s_ref1_re);
        r2a_c  = $unsigned(s_ref2_re[W-1] ? -s_ref2_re : s_ref2_re);
        flg_c.dzero = (dr_c == '0) && (di_c == '0);
        flg_c.rzero = (s_ref1_re == '0) || (s_ref2_re == '0);
        flg_c.z1neg = s_ref1_re[W-1];
        flg_c.z2neg = s_ref2_re[W-1];
    end

    logic signed [SW-1:0] dr1_reg, di1_reg;
    logic signed [SW-1:0] e1_reg [0:7];
    logic signed [W-1:0]  x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [W-1:0]  t_reg [0:7];
    logic [W-1:0]         r1a_reg, r2a_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dr1_reg <= dr_c;
            di1_reg <= di_c;
            for (int i = 0; i < 8; i++) e1_reg[i] <= e_c[i];
            x1_reg  <= s_ref1_re;
            y1_reg  <= s_ref1_im;
            x2_reg  <= s_ref2_re;
            y2_reg  <= s_ref2_im;
            t_reg[0] <= s_t11_re;
            t_reg[1] <= s_t11_im;
            t_reg[2] <= s_t12_re;
            t_reg[3] <= s_t12_im;
            t_reg[4] <= s_t21_re;
            t_reg[5] <= s_t21_im;
            t_reg[6] <= s_t22_re;
            t_reg[7] <= s_t22_im;
            r1a_reg <= r1a_c;
            r2a_reg <= r2a_c;
            flg_reg[1] <= flg_c;
            for (int i = 2; i < L; i++) flg_reg[i] <= flg_reg[i-1];
        end
    end

    // ---------------- stage 2: first-level products ------------------------
    logic signed [PW-1:0]  m_reg [0:7];
    logic signed [2*W-1:0] p_reg [0:7];
    logic signed [DDW-1:0] dr2_reg, di2_reg;
    logic signed [SW-1:0]  dr2c_reg, di2c_reg;
    logic [2*W-1:0]        rr_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_reg[0] <= PW'(e1_reg[0]) * PW'(x1_reg);
            m_reg[1] <= PW'(e1_reg[1]) * PW'(y1_reg);
            m_reg[2] <= PW'(e1_reg[2]) * PW'(y1_reg);
            m_reg[3] <= PW'(e1_reg[3]) * PW'(x1_reg);
            m_reg[4] <= PW'(e1_reg[4]) * PW'(x2_reg);
            m_reg[5] <= PW'(e1_reg[5]) * PW'(y2_reg);
            m_reg[6] <= PW'(e1_reg[6]) * PW'(y2_reg);
            m_reg[7] <= PW'(e1_reg[7]) * PW'(x2_reg);
            // determinant terms
            p_reg[0] <= (2*W)'(t_reg[0]) * (2*W)'(t_reg[6]);
            p_reg[1] <= (2*W)'(t_reg[1]) * (2*W)'(t_reg[7]);
            p_reg[2] <= (2*W)'(t_reg[2]) * (2*W)'(t_reg[4]);
            p_reg[3] <= (2*W)'(t_reg[3]) * (2*W)'(t_reg[5]);
            p_reg[4] <= (2*W)'(t_reg[0]) * (2*W)'(t_reg[7]);
            p_reg[5] <= (2*W)'(t_reg[1]) * (2*W)'(t_reg[6]);
            p_reg[6] <= (2*W)'(t_reg[2]) * (2*W)'(t_reg[5]);
            p_reg[7] <= (2*W)'(t_reg[3]) * (2*W)'(t_reg[4]);
            dr2_reg  <= DDW'(dr1_reg) * DDW'(dr1_reg);
            di2_reg  <= DDW'(di1_reg) * DDW'(di1_reg);
            dr2c_reg <= dr1_reg;
            di2c_reg <= di1_reg;
            rr_reg   <= (2*W)'(r1a_reg) * (2*W)'(r2a_reg);
        end
    end

    // ---------------- stage 3 and delay: numerators, det, |d|^2 ------------
    // Hold these while the square root runs alongside.
    logic signed [NW-1:0]  nr11_d [0:W-1];
    logic signed [NW-1:0]  ni11_d [0:W-1];
    logic signed [NW-1:0]  nr22_d [0:W-1];
    logic signed [NW-1:0]  ni22_d [0:W-1];
    logic signed [DTW-1:0] detr_d [0:W-1];
    logic signed [DTW-1:0] deti_d [0:W-1];
    logic [DDW-1:0]        dd_d   [0:W-1];
    logic signed [SW-1:0]  dr_d   [0:W-1];
    logic signed [SW-1:0]  di_d   [0:W-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            nr11_d[0] <= NW'(m_reg[0]) - NW'(m_reg[1]);
            ni11_d[0] <= NW'(m_reg[2]) + NW'(m_reg[3]);
            nr22_d[0] <= NW'(m_reg[4]) - NW'(m_reg[5]);
            ni22_d[0] <= NW'(m_reg[6]) + NW'(m_reg[7]);
            detr_d[0] <= DTW'(p_reg[0]) - DTW'(p_reg[1]) - DTW'(p_reg[2])
                       + DTW'(p_reg[3]);
            deti_d[0] <= DTW'(p_reg[4]) + DTW'(p_reg[5]) - DTW'(p_reg[6])
                       - DTW'(p_reg[7]);
            dd_d[0]   <= $unsigned(dr2_reg + di2_reg);
            dr_d[0]   <= dr2c_reg;
            di_d[0]   <= di2c_reg;
            for (int i = 1; i < W; i++) begin
                nr11_d[i] <= nr11_d[i-1];
                ni11_d[i] <= ni11_d[i-1];
                nr22_d[i] <= nr22_d[i-1];
                ni22_d[i] <= ni22_d[i-1];
                detr_d[i] <= detr_d[i-1];
                deti_d[i] <= deti_d[i-1];
                dd_d[i]   <= dd_d[i-1];
                dr_d[i]   <= dr_d[i-1];
                di_d[i]   <= di_d[i-1];
            end
        end
    end

    logic [W-1:0] root;

    tzp_sqrt #(
        .R_W (W)
    ) u_sqrt (
        .aclk (aclk),
        .en   (adv),
        .x    (rr_reg),
        .root (root)
    );

    // ---------------- stage X: signed 2*s for Z12 and Z21 -------------------
    logic signed [GW-1:0] s2_c;
    logic signed [TW-1:0] s2f_c;
    logic signed [GW-1:0] sg12_reg;
    logic signed [TW-1:0] n21_reg;
    logic signed [NW-1:0] xnr11_reg, xni11_reg, xnr22_reg, xni22_reg;
    logic signed [DTW-1:0] xdetr_reg, xdeti_reg;
    logic [DDW-1:0]       xdd_reg;
    logic signed [SW-1:0] xdr_reg, xdi_reg;

    assign s2_c  = $signed({1'b0, root, 1'b0});
    assign s2f_c = $signed({1'b0, root, 1'b0, {F{1'b0}}});

    always_ff @(posedge aclk) begin
        if (adv) begin
            sg12_reg  <= flg_reg[W+2].z2neg ? -s2_c : s2_c;
            n21_reg   <= flg_reg[W+2].z1neg ? -s2f_c : s2f_c;
            xnr11_reg <= nr11_d[W-1];
            xni11_reg <= ni11_d[W-1];
            xnr22_reg <= nr22_d[W-1];
            xni22_reg <= ni22_d[W-1];
            xdetr_reg <= detr_d[W-1];
            xdeti_reg <= deti_d[W-1];
            xdd_reg   <= dd_d[W-1];
            xdr_reg   <= dr_d[W-1];
            xdi_reg   <= di_d[W-1];
        end
    end

    // ---------------- stage Y1: Z12 det times signed 2*s, per half ----------
    // Split det into a low unsigned and a high signed half so each product
    // stays near the field width; the halves are merged in stage Y.
    logic signed [YPW-1:0] yp_reg [0:3];
    logic signed [NW-1:0]  wnr11_reg, wni11_reg, wnr22_reg, wni22_reg;
    logic signed [TW-1:0]  wn21_reg;
    logic [DDW-1:0]        wdd_reg;
    logic signed [SW-1:0]  wdr_reg, wdi_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            yp_reg[0] <= YPW'($signed({1'b0, xdetr_reg[CW-1:0]})) * YPW'(sg12_reg);
            yp_reg[1] <= YPW'($signed(xdetr_reg[DTW-1:CW])) * YPW'(sg12_reg);
            yp_reg[2] <= YPW'($signed({1'b0, xdeti_reg[CW-1:0]})) * YPW'(sg12_reg);
            yp_reg[3] <= YPW'($signed(xdeti_reg[DTW-1:CW])) * YPW'(sg12_reg);
            wnr11_reg <= xnr11_reg;
            wni11_reg <= xni11_reg;
            wnr22_reg <= xnr22_reg;
            wni22_reg <= xni22_reg;
            wn21_reg  <= n21_reg;
            wdd_reg   <= xdd_reg;
            wdr_reg   <= xdr_reg;
            wdi_reg   <= xdi_reg;
        end
    end

    // ---------------- stage Y: lane numerators (11, 12, 21, 22) -------------
    logic signed [MW-1:0] ln_nr_reg [0:3];
    logic signed [MW-1:0] ln_ni_reg [0:3];
    logic [DDW-1:0]       ydd_reg;
    logic signed [SW-1:0] ydr_reg, ydi_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ln_nr_reg[0] <= MW'(wnr11_reg);
            ln_ni_reg[0] <= MW'(wni11_reg);
            ln_nr_reg[1] <= MW'(yp_reg[0]) + (MW'(yp_reg[1]) <<< CW);
            ln_ni_reg[1] <= MW'(yp_reg[2]) + (MW'(yp_reg[3]) <<< CW);
            ln_nr_reg[2] <= MW'(wn21_reg);
            ln_ni_reg[2] <= '0;
            ln_nr_reg[3] <= MW'(wnr22_reg);
            ln_ni_reg[3] <= MW'(wni22_reg);
            ydd_reg <= wdd_reg;
            ydr_reg <= wdr_reg;
            ydi_reg <= wdi_reg;
        end
    end

    // ---------------- stage Z1: n * conj(d) partial products ---------------
    // Cut each lane numerator into two unsigned low chunks and a signed top.
    logic signed [GW-1:0]  nrc_c [0:3][0:2];
    logic signed [GW-1:0]  nic_c [0:3][0:2];
    logic signed [YPW-1:0] pa_reg [0:3][0:2];
    logic signed [YPW-1:0] pb_reg [0:3][0:2];
    logic signed [YPW-1:0] pc_reg [0:3][0:2];
    logic signed [YPW-1:0] pe_reg [0:3][0:2];
    logic [DDW-1:0]        z1dd_reg;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            nrc_c[k][0] = $signed({1'b0, ln_nr_reg[k][CW-1:0]});
            nrc_c[k][1] = $signed({1'b0, ln_nr_reg[k][2*CW-1:CW]});
            nrc_c[k][2] = ln_nr_reg[k][MW-1:2*CW];
            nic_c[k][0] = $signed({1'b0, ln_ni_reg[k][CW-1:0]});
            nic_c[k][1] = $signed({1'b0, ln_ni_reg[k][2*CW-1:CW]});
            nic_c[k][2] = ln_ni_reg[k][MW-1:2*CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                for (int c = 0; c < 3; c++) begin
                    pa_reg[k][c] <= YPW'(nrc_c[k][c]) * YPW'(ydr_reg);
                    pb_reg[k][c] <= YPW'(nic_c[k][c]) * YPW'(ydi_reg);
                    pc_reg[k][c] <= YPW'(nic_c[k][c]) * YPW'(ydr_reg);
                    pe_reg[k][c] <= YPW'(nrc_c[k][c]) * YPW'(ydi_reg);
                end
            end
            z1dd_reg <= ydd_reg;
        end
    end

    // ---------------- stage Z: merge the partial products ------------------
    logic signed [PZ-1:0] za_reg [0:3];
    logic signed [PZ-1:0] zb_reg [0:3];
    logic signed [PZ-1:0] zc_reg [0:3];
    logic signed [PZ-1:0] ze_reg [0:3];
    logic [DDW-1:0]       zdd_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                za_reg[k] <= PZ'(pa_reg[k][0]) + (PZ'(pa_reg[k][1]) <<< CW)
                           + (PZ'(pa_reg[k][2]) <<< (2 * CW));
                zb_reg[k] <= PZ'(pb_reg[k][0]) + (PZ'(pb_reg[k][1]) <<< CW)
                           + (PZ'(pb_reg[k][2]) <<< (2 * CW));
                zc_reg[k] <= PZ'(pc_reg[k][0]) + (PZ'(pc_reg[k][1]) <<< CW)
                           + (PZ'(pc_reg[k][2]) <<< (2 * CW));
                ze_reg[k] <= PZ'(pe_reg[k][0]) + (PZ'(pe_reg[k][1]) <<< CW)
                           + (PZ'(pe_reg[k][2]) <<< (2 * CW));
            end
            zdd_reg <= z1dd_reg;
        end
    end

    // ---------------- stage U: real and imaginary numerators ---------------
    logic signed [RW-1:0] u_reg [0:7];
    logic [DDW-1:0]       udd_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                u_reg[2*k]   <= RW'(za_reg[k]) + RW'(zb_reg[k]);
                u_reg[2*k+1] <= RW'(zc_reg[k]) - RW'(ze_reg[k]);
            end
            udd_reg <= zdd_reg;
        end
    end

    // ---------------- stage V: sign and magnitude, denominators ------------
    logic [RW-1:0]  mag_reg [0:7];
    logic           neg_reg [0:7];
    logic [DNW-1:0] den_reg;
    logic [DNW-1:0] den12_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 8; j++) begin
                mag_reg[j] <= $unsigned(u_reg[j][RW-1] ? -u_reg[j] : u_reg[j]);
                neg_reg[j] <= u_reg[j][RW-1];
            end
            den_reg   <= DNW'(udd_reg);
            den12_reg <= DNW'(udd_reg) << F;
        end
    end

    // ---------------- dividers and saturation ------------------------------
    logic [W-1:0]         q_w   [0:7];
    logic                 ovf_w [0:7];
    logic                 neg_w [0:7];
    logic signed [W-1:0]  fit_c [0:7];
    logic [7:0]           sat_c;

    for (genvar j = 0; j < 8; j++) begin : g_div
        tzp_div #(
            .Q_W   (W),
            .NUM_W (RW),
            .DEN_W (DNW)
        ) u_div (
            .aclk  (aclk),
            .en    (adv),
            .mag_i (mag_reg[j]),
            .neg_i (neg_reg[j]),
            .den_i ((j / 2 == 1) ? den12_reg : den_reg),
            .q_o   (q_w[j]),
            .ovf_o (ovf_w[j]),
            .neg_o (neg_w[j])
        );
    end

    localparam logic [W-1:0] LIM = W'(1) << (W - 1);

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            if (!neg_w[j]) begin
                sat_c[j] = ovf_w[j] || q_w[j][W-1];
                fit_c[j] = sat_c[j] ? $signed(LIM - W'(1)) : $signed(q_w[j]);
            end else begin
                sat_c[j] = ovf_w[j] || (q_w[j] > LIM);
                fit_c[j] = sat_c[j] ? $signed(LIM) : $signed(W'(0) - q_w[j]);
            end
        end
    end

    // ---------------- output register --------------------------------------
    logic signed [W-1:0] z_reg [0:7];
    tzp_pkg::status_t    status_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 8; j++) begin
                z_reg[j] <= (flg_reg[L-1].dzero || flg_reg[L-1].rzero) ? '0 : fit_c[j];
            end
            if (flg_reg[L-1].dzero) begin
                status_reg <= tzp_pkg::STAT_DIV_ZERO;
            end else if (flg_reg[L-1].rzero) begin
                status_reg <= tzp_pkg::STAT_REF_ZERO;
            end else if (|sat_c) begin
                status_reg <= tzp_pkg::STAT_SAT;
            end else begin
                status_reg <= tzp_pkg::STAT_OK;
            end
        end
    end

    assign m_z11_re = z_reg[0];
    assign m_z11_im = z_reg[1];
    assign m_z12_re = z_reg[2];
    assign m_z12_im = z_reg[3];
    assign m_z21_re = z_reg[4];
    assign m_z21_im = z_reg[5];
    assign m_z22_re = z_reg[6];
    assign m_z22_im = z_reg[7];
    assign m_status = status_reg;

    // ---------------- checks -----------------------------------------------
    `TZP_NEVER(a_stall_needs_held_out, aclk, aresetn,
        !s_ready && !(m_valid && !m_ready), "input stalled while output free")
    `TZP_ASSERT(a_divzero_clears, aclk, aresetn,
        (m_valid && m_status == tzp_pkg::STAT_DIV_ZERO) |->
        (m_z11_re == '0 && m_z12_im == '0 && m_z21_re == '0 && m_z22_im == '0),
        "zero divisor item carries data")
    `TZP_ASSERT(a_out_from_pipe, aclk, aresetn,
        $rose(m_valid) |-> $past(vld_reg[L-1]), "output valid without a pipeline item")

endmodule

FILE: design/tzp_sqrt.sv
// Pipelined floor square root, one result bit per stage.
// Depends on tzp_pkg for its default width; used by the converter top level.
module tzp_sqrt #(
    parameter int R_W = tzp_pkg::DATA_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [2*R_W-1:0] x,
    output logic [R_W-1:0]   root
);
    localparam int XW = 2 * R_W;

    logic [XW-1:0] rem_reg [0:R_W-1];
    logic [XW-1:0] res_reg [0:R_W-1];

    for (genvar k = 0; k < R_W; k++) begin : g_stage
        localparam logic [XW-1:0] ONE = XW'(1) << (2 * (R_W - 1 - k));
        logic [XW-1:0] rin;
        logic [XW-1:0] qin;
        logic [XW-1:0] trial;
        logic          ge;
        if (k == 0) begin : g_first
            assign rin = x;
            assign qin = '0;
        end else begin : g_rest
            assign rin = rem_reg[k-1];
            assign qin = res_reg[k-1];
        end
        assign trial = qin + ONE;
        assign ge    = (rin >= trial);
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? (rin - trial) : rin;
                res_reg[k] <= ge ? ((qin >> 1) + ONE) : (qin >> 1);
            end
        end
    end

    assign root = res_reg[R_W-1][R_W-1:0];

endmodule

FILE: design/tzp_div.sv
// Pipelined restoring divider: round(mag/den) to Q_W bits with overflow flag.
// Uses tzp_pkg for width helpers; one quotient bit per stage.
module tzp_div #(
    parameter int Q_W   = tzp_pkg::DATA_WIDTH_DEF,
    parameter int NUM_W = 4 * tzp_pkg::DATA_WIDTH_DEF + 7,
    parameter int DEN_W = 2 * tzp_pkg::DATA_WIDTH_DEF + 4 + tzp_pkg::FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] mag_i,
    input  logic             neg_i,
    input  logic [DEN_W-1:0] den_i,
    output logic [Q_W-1:0]   q_o,
    output logic             ovf_o,
    output logic             neg_o
);
    localparam int XW = tzp_pkg::imax(NUM_W + 2, DEN_W + 1 + Q_W);

    logic [XW-1:0]  n_a_reg;
    logic [XW-1:0]  d_a_reg;
    logic           neg_a_reg;
    logic [XW-1:0]  r_reg   [0:Q_W];
    logic [XW-1:0]  d_reg   [0:Q_W];
    logic [Q_W-1:0] q_reg   [0:Q_W];
    logic           ovf_reg [0:Q_W];
    logic           neg_reg [0:Q_W];

    // form 2*mag + den over 2*den for round half away from zero
    always_ff @(posedge aclk) begin
        if (en) begin
            n_a_reg   <= (XW'(mag_i) << 1) + XW'(den_i);
            d_a_reg   <= XW'(den_i) << 1;
            neg_a_reg <= neg_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= n_a_reg;
            d_reg[0]   <= d_a_reg;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (n_a_reg >= (d_a_reg << Q_W));
            neg_reg[0] <= neg_a_reg;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_bit
        localparam int B = Q_W - k;
        logic [XW-1:0] dsh;
        logic          ge;
        assign dsh = d_reg[k-1] << B;
        assign ge  = (r_reg[k-1] >= dsh);
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k]   <= ge ? (r_reg[k-1] - dsh) : r_reg[k-1];
                d_reg[k]   <= d_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | (ge ? (Q_W'(1) << B) : '0);
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign q_o   = q_reg[Q_W];
    assign ovf_o = ovf_reg[Q_W];
    assign neg_o = neg_reg[Q_W];

endmodule
